/* rtl/ocsws_pkg.sv */
package ocsws_pkg;

   // request word layout
   localparam int ACT_W      = 2;
   localparam int WIDX_W     = 4;
   localparam int WVAL_W     = 16;
   localparam int MASK_W     = 64;
   localparam int FRAC_W     = 16;
   localparam int REQ_DATA_W = 104;

   // response word layout
   localparam int CHOSEN_W   = 6;
   localparam int RSP_DATA_W = 8;

   typedef logic [ACT_W-1:0] action_type;

   localparam action_type ACT_CLEAR = 2'd0;
   localparam action_type ACT_LOAD  = 2'd1;
   localparam action_type ACT_ROUND = 2'd2;

endpackage

/* rtl/semi_ocs_weighted_selector.sv */
// weighted roulette-wheel selector
//
// req channel: one word per command. tuser carries the action (clear element
// state, load one weight table word, run a selection round); tdata carries
// the table index, the weight, the offer mask and the random fraction.
// rsp channel: one word for each round, none for clear or load. tdata holds
// the chosen element, tuser flags that nothing was chosen.
//
// a clear or load word is taken without leaving idle. a round passes twice
// over the element slots on the shared adder (sum, then re-accumulate and
// compare), with a multiply state between and a final state that loads
// the result into the output register. req_tready is low while a round is
// in progress.
//
// the result sits in an output register; a new command is accepted while
// it waits, but a following round holds in its final state until rsp_tready
// frees the register. reset clears appearance counts and selected flags at
// once; the weight table holds nothing defined until loaded.
module semi_ocs_weighted_selector
   import ocsws_pkg::*;
#(
   parameter int ELEMENTS    = 64,
   parameter int MAX_APPEAR  = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // fields from bit 0: weight_index[3:0], weight_value[15:0],
   // offer_mask[63:0], random_fraction[15:0], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // fields from bit 0: action[1:0]
   input  logic [ACT_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // fields from bit 0: chosen_element[5:0], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // fields from bit 0: nothing_chosen
   output logic                  rsp_tuser
);

   localparam int IDX_W = $clog2(ELEMENTS);
   localparam int CNT_W = $clog2(MAX_APPEAR);
   localparam int SUM_W = WEIGHT_BITS + IDX_W;
   localparam int TGT_W = SUM_W + FRAC_W;
   localparam logic [IDX_W:0]   ELEM_CNT = (IDX_W+1)'(ELEMENTS);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_APPEAR - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PASS1 = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_PASS2 = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // request word fields
   action_type          req_action;
   logic [WIDX_W-1:0]   req_widx;
   logic [WVAL_W-1:0]   req_wval;
   logic [MASK_W-1:0]   req_mask;
   logic [FRAC_W-1:0]   req_frac;

   assign req_action = req_tuser;
   assign req_widx   = req_tdata[WIDX_W-1:0];
   assign req_wval   = req_tdata[WIDX_W +: WVAL_W];
   assign req_mask   = req_tdata[WIDX_W+WVAL_W +: MASK_W];
   assign req_frac   = req_tdata[WIDX_W+WVAL_W+MASK_W +: FRAC_W];

   // control registers
   logic [2:0]          state_ff, state_in;
   logic [IDX_W:0]      iss_ff, iss_in;
   logic                st1_ff, st1_in;
   logic                st2_ff, st2_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ELEMENTS-1:0] cvalid_ff;
   logic [ELEMENTS-1:0] sel_ff;

   // payload registers
   logic [ELEMENTS-1:0] mask_ff, mask_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [TGT_W-1:0]    target_ff, target_in;
   logic                tot_zero_ff, tot_zero_in;
   logic [IDX_W-1:0]    idx1_ff, idx2_ff;
   logic                cval1_ff, sel1_ff, off1_ff, elig2_ff;
   logic [IDX_W-1:0]    chosen_ff, chosen_in;
   logic [CHOSEN_W-1:0] rsp_chosen_ff, rsp_chosen_in;
   logic                rsp_none_ff, rsp_none_in;

   // memories and their registered read data
   logic [WEIGHT_BITS-1:0] weight_mem_ff [MAX_APPEAR];
   logic [CNT_W-1:0]       count_mem_ff  [ELEMENTS];
   logic [WEIGHT_BITS-1:0] elem_w_mem_ff [ELEMENTS];
   logic [WEIGHT_BITS-1:0] wt_rd_ff;
   logic [CNT_W-1:0]       cnt_rd_ff;
   logic [WEIGHT_BITS-1:0] ew_rd_ff;

   logic                   req_fire;
   logic                   in_pass1, in_pass2, issue, pass_empty;
   logic [IDX_W-1:0]       iss_addr;
   logic [CNT_W-1:0]       cnt_eff, cnt_next;
   logic                   cnt_we, ew_we, tbl_we, hit, done_fire, do_add;
   logic [CNT_W-1:0]       tbl_addr;
   logic [WEIGHT_BITS-1:0] wt_w, add_op;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign in_pass1   = (state_ff == ST_PASS1);
   assign in_pass2   = (state_ff == ST_PASS2);
   assign issue      = (in_pass1 || in_pass2) && (iss_ff != ELEM_CNT);
   assign pass_empty = !issue && !st1_ff && !st2_ff;
   assign iss_addr   = iss_ff[IDX_W-1:0];

   // pass 1, stage 1: effective count and its saturating update
   assign cnt_eff  = cval1_ff ? cnt_rd_ff : '0;
   assign cnt_next = (cnt_eff != CNT_MAX) ? cnt_eff + CNT_W'(1) : cnt_eff;
   assign cnt_we   = in_pass1 && st1_ff && off1_ff;

   // pass 1, stage 2: eligible weight, kept per element for pass 2
   assign wt_w  = elig2_ff ? wt_rd_ff : '0;
   assign ew_we = in_pass1 && st2_ff;

   // shared accumulator: stage 2 in pass 1, stage 1 in pass 2
   assign add_op = in_pass1 ? wt_w : ew_rd_ff;
   assign do_add = (in_pass1 && st2_ff) || (in_pass2 && st1_ff);

   // pass 2, stage 2: first running sum that reaches the target
   assign hit = in_pass2 && st2_ff && !found_ff && !tot_zero_ff &&
                ({acc_ff, FRAC_W'(0)} >= target_ff);

   assign tbl_we   = req_fire && (req_action == ACT_LOAD) &&
                     (32'(req_widx) < 32'(MAX_APPEAR));
   assign tbl_addr = CNT_W'(req_widx);

   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      iss_in        = issue ? iss_ff + (IDX_W+1)'(1) : iss_ff;
      st1_in        = issue;
      st2_in        = st1_ff;
      found_in      = found_ff || hit;
      chosen_in     = hit ? idx2_ff : chosen_ff;
      acc_in        = do_add ? acc_ff + SUM_W'(add_op) : acc_ff;
      mask_in       = mask_ff;
      frac_in       = frac_ff;
      target_in     = target_ff;
      tot_zero_in   = tot_zero_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_none_in   = rsp_none_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_action == ACT_ROUND)) begin
               state_in = ST_PASS1;
               iss_in   = '0;
               acc_in   = '0;
               found_in = 1'b0;
               mask_in  = req_mask[ELEMENTS-1:0];
               // a zero draw counts as the smallest one
               frac_in  = (req_frac == '0) ? FRAC_W'(1) : req_frac;
            end
         end
         ST_PASS1: begin
            if (pass_empty) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            target_in   = TGT_W'(frac_ff) * TGT_W'(acc_ff);
            tot_zero_in = (acc_ff == '0);
            acc_in      = '0;
            iss_in      = '0;
            state_in    = ST_PASS2;
         end
         ST_PASS2: begin
            if (pass_empty) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_chosen_in = found_ff ? CHOSEN_W'(chosen_ff) : '0;
               rsp_none_in   = !found_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_ff       <= '0;
         st1_ff       <= 1'b0;
         st2_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cvalid_ff    <= '0;
         sel_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         st1_ff       <= st1_in;
         st2_ff       <= st2_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire && (req_action == ACT_CLEAR)) begin
            cvalid_ff <= '0;
            sel_ff    <= '0;
         end else begin
            if (cnt_we) begin
               cvalid_ff[idx1_ff] <= 1'b1;
            end
            if (done_fire && found_ff) begin
               sel_ff[chosen_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      mask_ff       <= mask_in;
      frac_ff       <= frac_in;
      acc_ff        <= acc_in;
      target_ff     <= target_in;
      tot_zero_ff   <= tot_zero_in;
      chosen_ff     <= chosen_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_none_ff   <= rsp_none_in;
      // slot pipeline
      idx1_ff  <= iss_addr;
      idx2_ff  <= idx1_ff;
      cval1_ff <= cvalid_ff[iss_addr];
      sel1_ff  <= sel_ff[iss_addr];
      off1_ff  <= mask_ff[iss_addr];
      elig2_ff <= off1_ff && !sel1_ff;
   end

   // weight table, read by effective appearance count
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         weight_mem_ff[tbl_addr] <= WEIGHT_BITS'(req_wval);
      end
      wt_rd_ff <= weight_mem_ff[cnt_eff];
   end

   // appearance counts
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem_ff[idx1_ff] <= cnt_next;
      end
      cnt_rd_ff <= count_mem_ff[iss_addr];
   end

   // per-element eligible weight of the current round
   always_ff @(posedge clock) begin
      if (ew_we) begin
         elem_w_mem_ff[idx2_ff] <= wt_w;
      end
      ew_rd_ff <= elem_w_mem_ff[iss_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_chosen_ff);
   assign rsp_tuser  = rsp_none_ff;

   // slot pipeline only fills from its own issue stage
   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      st2_ff |-> $past(st1_ff))
      else $error("slot pipeline stage 2 without stage 1");

   // pipeline is drained whenever a new command may enter
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!st1_ff && !st2_ff))
      else $error("slot pipeline busy while idle");

   // a zero total never yields a choice
   a_zero_total: assert property (@(posedge clock) disable iff (reset)
      (in_pass2 && tot_zero_ff) |=> !found_ff)
      else $error("element chosen with zero total weight");

   // a new response only leaves the final state of a round
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready)) |->
         $past(state_ff == ST_DONE))
      else $error("response loaded outside the final state");

   // counts are only written back during the first pass
   a_count_write: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> (state_ff == ST_PASS1))
      else $error("count write outside first pass");

endmodule

/* tb/sv/roulette_checker.sv */
`timescale 1ns / 100ps

module roulette_checker
   import ocsws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [ACT_W-1:0]      req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   output int                    fail_count,
   output int                    picks_pending,
   output int                    rounds_checked,
   output int                    empty_rounds
);

   localparam int SLOTS     = 64;
   localparam int LUT_DEPTH = 16;
   localparam logic [3:0] CNT_CAP = 4'd15;

   // request word field offsets
   localparam int WVAL_LO = WIDX_W;
   localparam int MASK_LO = WVAL_LO + WVAL_W;
   localparam int FRAC_LO = MASK_LO + MASK_W;

   typedef struct packed {
      logic [CHOSEN_W-1:0] element;
      logic                none;
   } pick_type;

   logic [3:0]        appear_cnt [SLOTS];
   bit                taken      [SLOTS];
   logic [WVAL_W-1:0] weight_lut [LUT_DEPTH];
   pick_type          expected_picks [$];

   initial begin
      fail_count     = 0;
      picks_pending  = 0;
      rounds_checked = 0;
      empty_rounds   = 0;
   end

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: rsp %s got %0h, expected %0h", $time, field, got, want);
      fail_count++;
   endtask

   // one turn of the wheel: pick, mark and bump the counts
   function automatic pick_type spin_wheel(input logic [MASK_W-1:0] offer,
                                           input logic [FRAC_W-1:0] draw);
      logic [63:0] sums [SLOTS];
      logic [63:0] total;
      logic [63:0] target;
      pick_type    pick;
      bit          found;
      total = '0;
      found = 1'b0;
      pick  = '{element: '0, none: 1'b1};
      if (draw == '0)
         draw = FRAC_W'(1);
      for (int x = 0; x < SLOTS; x++) begin
         sums[x] = '0;
         if (offer[x] && !taken[x]) begin
            total   = total + weight_lut[appear_cnt[x]];
            sums[x] = total;
         end
      end
      if (total != '0) begin
         target = draw * total;
         for (int x = 0; x < SLOTS; x++) begin
            if (!found && offer[x] && !taken[x] && (sums[x] << 16) >= target) begin
               found        = 1'b1;
               pick.element = CHOSEN_W'(x);
            end
         end
      end
      if (found) begin
         taken[pick.element] = 1'b1;
         pick.none           = 1'b0;
      end
      for (int x = 0; x < SLOTS; x++)
         if (offer[x] && appear_cnt[x] != CNT_CAP)
            appear_cnt[x]++;
      return pick;
   endfunction

   task automatic check_pick();
      pick_type want;
      if (expected_picks.size() == 0) begin
         report("word with no round waiting", 64'({rsp_tuser, rsp_tdata}), '0);
         return;
      end
      want = expected_picks.pop_front();
      rounds_checked++;
      if (want.none)
         empty_rounds++;
      if (rsp_tdata[CHOSEN_W-1:0] !== want.element)
         report("chosen_element", 64'(rsp_tdata[CHOSEN_W-1:0]), 64'(want.element));
      if (rsp_tuser !== want.none)
         report("nothing_chosen", 64'(rsp_tuser), 64'(want.none));
      if (rsp_tdata[RSP_DATA_W-1:CHOSEN_W] !== '0)
         report("tdata fill", 64'(rsp_tdata[RSP_DATA_W-1:CHOSEN_W]), '0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int x = 0; x < SLOTS; x++) begin
            appear_cnt[x] = '0;
            taken[x]      = 1'b0;
         end
         expected_picks.delete();
      end else begin
         // results first, they always belong to earlier rounds
         if (rsp_tvalid && rsp_tready)
            check_pick();
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               ACT_CLEAR: begin
                  for (int x = 0; x < SLOTS; x++) begin
                     appear_cnt[x] = '0;
                     taken[x]      = 1'b0;
                  end
               end
               ACT_LOAD: begin
                  weight_lut[req_tdata[WIDX_W-1:0]] = req_tdata[WVAL_LO +: WVAL_W];
               end
               ACT_ROUND: begin
                  expected_picks.push_back(spin_wheel(req_tdata[MASK_LO +: MASK_W],
                                                      req_tdata[FRAC_LO +: FRAC_W]));
               end
               default: ;
            endcase
         end
      end
      picks_pending = expected_picks.size();
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import ocsws_pkg::*;

   // spare action code, the block must ignore it
   localparam action_type ACT_SPARE = 2'd3;

   localparam int WORDS_WANTED    = 2000;
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int HOLD_OFF_CYCLES = 1500;
   // leave room for a straggler round
   localparam int DRAIN_CYCLES    = 2 * 64 + 60;
   localparam int FILL_W          = REQ_DATA_W - WIDX_W - WVAL_W - MASK_W - FRAC_W;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // fields from bit 0: weight_index, weight_value, offer_mask, random_fraction, zero fill
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // fields from bit 0: action
   logic [ACT_W-1:0]      req_tuser  = ACT_CLEAR;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // fields from bit 0: chosen_element, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // fields from bit 0: nothing_chosen
   logic                  rsp_tuser;

   int fail_count;
   int picks_pending;
   int rounds_checked;
   int empty_rounds;

   // sender pacing and tallies
   int burst_left  = 0;
   int words_sent  = 0;
   int loads_sent  = 0;
   int clears_sent = 0;
   int spares_sent = 0;
   int cycles      = 0;

   semi_ocs_weighted_selector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   roulette_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .fail_count     (fail_count),
      .picks_pending  (picks_pending),
      .rounds_checked (rounds_checked),
      .empty_rounds   (empty_rounds)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d rounds still awaited", cycles, picks_pending);
         $display("** semi_ocs_weighted_selector: FAILED **");
         $finish;
      end
   end

   // offer one word; the pause between bursts comes first so that
   // tvalid is never lowered and raised in the same step
   task automatic send_word(input action_type act, input logic [WIDX_W-1:0] widx,
                            input logic [WVAL_W-1:0] wval, input logic [MASK_W-1:0] mask,
                            input logic [FRAC_W-1:0] frac);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1, 2:    gap = $urandom_range(1, 8);
            default: gap = $urandom_range(9, 160); // long enough to land mid-round
         endcase
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tuser  <= act;
      req_tdata  <= {{FILL_W{1'b0}}, frac, mask, wval, widx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      case (act)
         ACT_LOAD:  loads_sent++;
         ACT_CLEAR: clears_sent++;
         default: ;
      endcase
      if (act == ACT_SPARE)
         spares_sent++;
      else
         words_sent++;
   endtask

   // result side: its own stall pattern, plus one long hold-off so the
   // output register fills, the next round parks and req_tready drops
   initial begin : rsp_side
      int mode;
      int run_len;
      int spent;
      bit held_off;
      spent    = 0;
      held_off = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!held_off && spent >= 6000) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            held_off = 1'b1;
         end
         mode    = $urandom_range(0, 3);
         run_len = $urandom_range(20, 400);
         for (int i = 0; i < run_len; i++) begin
            case (mode)
               0:       rsp_tready <= 1'b1;                       // no stalls
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 7) == 0); // mostly stalled
            endcase
            @(posedge clock);
         end
         spent += run_len;
      end
   end

   initial begin : stimulus
      logic [WVAL_W-1:0] val;
      logic [MASK_W-1:0] mask;
      logic [FRAC_W-1:0] frac;
      int profile;
      int n_rounds;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----

      // fill the whole weight table first, no round may read an unloaded entry
      for (int i = 0; i < 16; i++) begin
         if (i == 1)
            val = '0;
         else if (i == 0 || i == 15)
            val = '1;
         else
            val = WVAL_W'($urandom_range(1, 65534));
         send_word(ACT_LOAD, WIDX_W'(i), val, {$urandom, $urandom}, FRAC_W'($urandom));
      end
      // full offer, smallest and largest draw
      send_word(ACT_ROUND, '0, '0, '1, 16'd1);
      send_word(ACT_ROUND, '1, '1, '1, 16'hFFFF);
      // zero draw behaves as the smallest one
      send_word(ACT_ROUND, 4'd5, 16'h5A5A, '1, 16'd0);
      // nothing offered
      send_word(ACT_ROUND, '0, '0, '0, 16'h8000);
      // top element alone, then again once it is already selected
      send_word(ACT_ROUND, '0, '0, 64'h8000_0000_0000_0000, 16'h1234);
      send_word(ACT_ROUND, '0, '0, 64'h8000_0000_0000_0000, 16'hFEDC);
      // unused action code
      send_word(ACT_SPARE, '1, '1, '1, '1);
      // clear keeps the table, element 0 fresh again
      send_word(ACT_CLEAR, '0, '0, '0, '0);
      send_word(ACT_ROUND, '0, '0, 64'd1, 16'hFFFF);
      // fresh elements weigh nothing now: offered but zero total
      send_word(ACT_LOAD, 4'd0, 16'h0000, '0, '0);
      send_word(ACT_ROUND, '0, '0, '1, 16'h4000);
      send_word(ACT_LOAD, 4'd0, 16'hFFFF, '0, '0);

      // ---- random part: sessions of clear, optional reload, rounds ----
      while (words_sent < WORDS_WANTED) begin
         // skipping the clear now and then lets selections pile up
         if ($urandom_range(0, 4) != 0)
            send_word(ACT_CLEAR, WIDX_W'($urandom), WVAL_W'($urandom),
                      {$urandom, $urandom}, FRAC_W'($urandom));
         if ($urandom_range(0, 2) == 0) begin
            profile = $urandom_range(0, 5);
            for (int i = 0; i < 16; i++) begin
               // the last profile reloads only a few entries
               if (profile != 5 || $urandom_range(0, 3) == 0) begin
                  case (profile)
                     0:       val = WVAL_W'($urandom);
                     1:       val = WVAL_W'($urandom_range(0, 15));  // tiny weights
                     2:       val = ($urandom_range(0, 2) == 0) ? '0 : WVAL_W'($urandom);
                     3:       val = '1;                              // all at maximum
                     4:       val = 16'hFFFF >> i;                   // decaying with count
                     default: val = ($urandom_range(0, 3) == 0) ? '0 : WVAL_W'($urandom);
                  endcase
                  send_word(ACT_LOAD, WIDX_W'(i), val, {$urandom, $urandom},
                            FRAC_W'($urandom));
               end
            end
         end
         n_rounds = $urandom_range(4, 40);
         for (int r = 0; r < n_rounds; r++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: mask = {$urandom, $urandom};
               3, 4: begin
                  mask = '0;
                  repeat ($urandom_range(1, 6)) mask[6'($urandom_range(0, 63))] = 1'b1;
               end
               5:       mask = '1;
               6:       mask = 64'd1 << $urandom_range(0, 63);
               7:       mask = '0;
               8:       mask = ({MASK_W{1'b1}} >> $urandom_range(0, 63)) << $urandom_range(0, 63);
               default: mask = {$urandom, $urandom} | {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 15))
               0:       frac = '0;
               1:       frac = 16'd1;
               2:       frac = '1;
               default: frac = FRAC_W'($urandom_range(1, 65535));
            endcase
            send_word(ACT_ROUND, WIDX_W'($urandom), WVAL_W'($urandom), mask, frac);
            // noise inside a session: spare code or a stray table write
            if ($urandom_range(0, 49) == 0)
               send_word(ACT_SPARE, WIDX_W'($urandom), WVAL_W'($urandom),
                         {$urandom, $urandom}, FRAC_W'($urandom));
            if ($urandom_range(0, 29) == 0)
               send_word(ACT_LOAD, WIDX_W'($urandom), WVAL_W'($urandom),
                         {$urandom, $urandom}, FRAC_W'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      // drain: every round answered, then a little extra for stray words
      while (picks_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words: %0d table loads, %0d clears, %0d spare-code words",
               words_sent, loads_sent, clears_sent, spares_sent);
      $display("checked %0d rounds (%0d with nothing chosen), one %0d-cycle result hold-off",
               rounds_checked, empty_rounds, HOLD_OFF_CYCLES);
      if (fail_count == 0)
         $display("** semi_ocs_weighted_selector: PASSED **");
      else
         $display("** semi_ocs_weighted_selector: FAILED **");
      $finish;
   end

endmodule

/* filelist.f */
rtl/ocsws_pkg.sv
rtl/semi_ocs_weighted_selector.sv
tb/sv/roulette_checker.sv
tb/sv/tb_top.sv
